// ===== sv/prac_pkg.sv =====
// Package for the point rotator: fixed-point constants, register indexes,
// reset values and the sine table generator used at elaboration.
// No dependencies.
package prac_pkg;

    // Angle format: units of 2^-ANGLE_FRAC_BITS radian
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ANGLE_W         = 19;
    localparam longint unsigned WRAP_UNITS =
        ((64'd628318 << ANGLE_FRAC_BITS) + 64'd50000) / 64'd100000;

    // Sine table size, log2
    localparam int SINE_TABLE_BITS = 10;

    // Field widths
    localparam int COORD_W = 10;
    localparam int STEP_W  = 16;
    localparam int OUT_W   = 12;
    localparam int TRIG_W  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd4;

    localparam logic [STEP_W-1:0] ANGLE_STEP_RESET = 16'd3277;

    // pi in Q2.30
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Series term divisors 2k(2k+1), k = 1..12, as ceil(2^42 / d).
    // Multiply and shift by 42 gives the exact floor quotient for terms below 2^32.
    localparam int SERIES_SHIFT = 42;
    localparam longint unsigned SERIES_SCALE = 64'd1 << SERIES_SHIFT;
    localparam longint unsigned SERIES_RECIP [12] = '{
        (SERIES_SCALE + 64'd5)   / 64'd6,
        (SERIES_SCALE + 64'd19)  / 64'd20,
        (SERIES_SCALE + 64'd41)  / 64'd42,
        (SERIES_SCALE + 64'd71)  / 64'd72,
        (SERIES_SCALE + 64'd109) / 64'd110,
        (SERIES_SCALE + 64'd155) / 64'd156,
        (SERIES_SCALE + 64'd209) / 64'd210,
        (SERIES_SCALE + 64'd271) / 64'd272,
        (SERIES_SCALE + 64'd341) / 64'd342,
        (SERIES_SCALE + 64'd419) / 64'd420,
        (SERIES_SCALE + 64'd505) / 64'd506,
        (SERIES_SCALE + 64'd599) / 64'd600
    };

    // sin(pi/2 * j / quarter) in Q1.15, Taylor series in Q30, non-negative
    function automatic logic [TRIG_W-1:0] quarter_sine(input longint unsigned j,
                                                      input int unsigned tb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned q15;
        logic [75:0]     scaled;
        x    = ((PI_Q30 >> 1) * j) >> (tb - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 12; k++) begin
            term   = (term * x2) >> 30;
            scaled = 76'(term) * 76'(SERIES_RECIP[k-1]);
            term   = 64'(scaled >> SERIES_SHIFT);
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q15 = (longint'(sum) + 64'd16384) >> 15;
        if (q15 > 64'd32767) begin
            q15 = 64'd32767;
        end
        return q15[TRIG_W-1:0];
    endfunction

    // Full-circle table entry i of 2^tb, Q1.15 two's complement
    function automatic logic signed [TRIG_W-1:0] table_sine(input int unsigned i,
                                                           input int unsigned tb);
        longint unsigned quarter;
        longint unsigned quad;
        longint unsigned r;
        logic [TRIG_W-1:0] mag;
        quarter = 64'd1 << (tb - 2);
        quad    = (longint'(i) >> (tb - 2)) & 64'd3;
        r       = longint'(i) & (quarter - 64'd1);
        if (quad == 64'd0 || quad == 64'd2) begin
            mag = quarter_sine(r, tb);
        end else begin
            mag = quarter_sine(quarter - r, tb);
        end
        if (quad >= 64'd2) begin
            return -$signed(mag);
        end
        return $signed(mag);
    endfunction

endpackage

// ===== sv/point_rotator_about_centre_unit.sv =====
// Point rotator about a pivot: angle accumulator, sine/cosine ROM, rotation.
// Depends on prac_pkg (constants, register indexes, sine table generator).
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+-----------------
//  input   | s_advance                               | in        | s_valid/s_ready
//  result  | m_rotated_x, m_rotated_y, m_current_angle| out      | m_valid/m_ready
//  config  | cfg_index, cfg_data                     | in        | cfg_valid/cfg_ready
//
// Six-stage pipeline, one request per cycle sustained while the output is not
// stalled. The stages, in order: angle update, reciprocal multiply, index
// correction, ROM read, products, sum and saturate. Each stage holds its
// request when the next one is full, so bubbles close up under output stalls.
// Reset clears the angle, the configuration registers (the angle step takes
// its reset value) and all valid bits; no clearing pass.
module point_rotator_about_centre_unit #(
    parameter int SINE_TABLE_BITS = prac_pkg::SINE_TABLE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_advance,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [prac_pkg::OUT_W-1:0]    m_rotated_x,
    output logic signed [prac_pkg::OUT_W-1:0]    m_rotated_y,
    output logic [prac_pkg::ANGLE_W-1:0]         m_current_angle,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [prac_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [prac_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int TB         = SINE_TABLE_BITS;
    localparam int TABLE_SIZE = 1 << TB;
    localparam int QUARTER    = TABLE_SIZE / 4;
    localparam int AW         = prac_pkg::ANGLE_W;
    localparam int CW         = prac_pkg::COORD_W;
    localparam int OW         = prac_pkg::OUT_W;
    localparam int TW         = prac_pkg::TRIG_W;
    localparam int PW         = CW + 1 + TW;   // product width
    localparam int SW         = OW + 1;        // pre-saturation sum width
    // index = round(angle * T / WRAP) = floor(N / D)
    localparam int NW         = AW + TB + 2;
    localparam int QW         = TB + 1;
    localparam int MW         = TB + 2;
    localparam longint unsigned DIV   = 2 * prac_pkg::WRAP_UNITS;
    localparam longint unsigned RECIP = (64'd1 << NW) / DIV;
    localparam logic [NW-1:0] WRAP_N  = NW'(prac_pkg::WRAP_UNITS);
    localparam logic [NW-1:0] DIV_N   = NW'(DIV);
    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
    localparam logic [AW:0]   WRAP_A  = (AW + 1)'(prac_pkg::WRAP_UNITS);

    // Truncate a Q15 product toward zero
    function automatic logic signed [OW-1:0] trunc_q15(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] adj;
        adj = p + (p[PW-1] ? PW'(32767) : PW'(0));
        return adj[PW-1 -: OW];
    endfunction

    // Saturate to the output range
    function automatic logic signed [OW-1:0] sat_out(input logic signed [SW-1:0] v);
        if (v[SW-1] != v[SW-2]) begin
            return v[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        end
        return v[OW-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CW-1:0]                  centre_x_reg, centre_y_reg;
    logic [CW-1:0]                  point_x_reg, point_y_reg;
    logic [prac_pkg::STEP_W-1:0]    angle_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg   <= '0;
            centre_y_reg   <= '0;
            point_x_reg    <= '0;
            point_y_reg    <= '0;
            angle_step_reg <= prac_pkg::ANGLE_STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                prac_pkg::REG_CENTRE_X:   centre_x_reg   <= cfg_data[CW-1:0];
                prac_pkg::REG_CENTRE_Y:   centre_y_reg   <= cfg_data[CW-1:0];
                prac_pkg::REG_POINT_X:    point_x_reg    <= cfg_data[CW-1:0];
                prac_pkg::REG_POINT_Y:    point_y_reg    <= cfg_data[CW-1:0];
                prac_pkg::REG_ANGLE_STEP: angle_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage handshake: a stage loads when empty or when it moves on
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic s_accept;

    assign rdy6     = !v6_reg || m_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_ready  = rdy1;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: angle accumulator, single wrap subtraction
    // ---------------------------------------------------------------
    logic [AW-1:0] acc_reg, acc_next;
    logic [AW:0]   acc_sum;
    logic [AW-1:0] angle1_reg;

    always_comb begin
        acc_sum  = {1'b0, acc_reg} + (AW + 1)'(angle_step_reg);
        acc_next = acc_reg;
        if (s_advance) begin
            acc_next = (acc_sum >= WRAP_A) ? AW'(acc_sum - WRAP_A) : acc_sum[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (s_accept) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            angle1_reg <= acc_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: N = 2T*angle + WRAP, quotient estimate by reciprocal
    // ---------------------------------------------------------------
    logic [NW-1:0]    n_comb;
    logic [NW+MW-1:0] recip_prod;
    logic [NW-1:0]    n2_reg;
    logic [QW-1:0]    q2_reg;
    logic [AW-1:0]    angle2_reg;

    assign n_comb     = (NW'(angle1_reg) << (TB + 1)) + WRAP_N;
    assign recip_prod = (NW + MW)'(n_comb) * (NW + MW)'(RECIP_M);

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            n2_reg     <= n_comb;
            q2_reg     <= recip_prod[NW +: QW];
            angle2_reg <= angle1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: correct the estimate by one, wrap to table size
    // ---------------------------------------------------------------
    logic [NW-1:0] qd_comb, rem_comb;
    logic [QW-1:0] q_fix;
    logic [TB-1:0] idx3_reg;
    logic [AW-1:0] angle3_reg;

    assign qd_comb  = NW'(q2_reg) * DIV_N;
    assign rem_comb = n2_reg - qd_comb;
    assign q_fix    = q2_reg + QW'(rem_comb >= DIV_N);

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            idx3_reg   <= q_fix[TB-1:0];
            angle3_reg <= angle2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: sine ROM, two registered read ports
    // ---------------------------------------------------------------
    logic signed [TW-1:0] sine_rom [TABLE_SIZE];
    logic [TB-1:0]        cos_idx;
    logic signed [TW-1:0] sin4_reg, cos4_reg;
    logic [AW-1:0]        angle4_reg;

    for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
        assign sine_rom[gi] = prac_pkg::table_sine(gi, TB);
    end

    assign cos_idx = idx3_reg + TB'(QUARTER);

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            sin4_reg   <= sine_rom[idx3_reg];
            cos4_reg   <= sine_rom[cos_idx];
            angle4_reg <= angle3_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: four products, truncated toward zero
    // ---------------------------------------------------------------
    logic signed [CW:0]   dx, dy;
    logic signed [PW-1:0] p_xc, p_ys, p_xs, p_yc;
    logic signed [OW-1:0] t_xc5_reg, t_ys5_reg, t_xs5_reg, t_yc5_reg;
    logic [AW-1:0]        angle5_reg;

    assign dx   = $signed({1'b0, point_x_reg}) - $signed({1'b0, centre_x_reg});
    assign dy   = $signed({1'b0, point_y_reg}) - $signed({1'b0, centre_y_reg});
    assign p_xc = PW'(dx) * PW'(cos4_reg);
    assign p_ys = PW'(dy) * PW'(sin4_reg);
    assign p_xs = PW'(dx) * PW'(sin4_reg);
    assign p_yc = PW'(dy) * PW'(cos4_reg);

    always_ff @(posedge aclk) begin
        if (rdy5 && v4_reg) begin
            t_xc5_reg  <= trunc_q15(p_xc);
            t_ys5_reg  <= trunc_q15(p_ys);
            t_xs5_reg  <= trunc_q15(p_xs);
            t_yc5_reg  <= trunc_q15(p_yc);
            angle5_reg <= angle4_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: add the pivot, saturate, output register
    // ---------------------------------------------------------------
    logic signed [SW-1:0] x_sum, y_sum;
    logic signed [OW-1:0] x6_reg, y6_reg;
    logic [AW-1:0]        angle6_reg;

    assign x_sum = $signed(SW'({1'b0, centre_x_reg})) + SW'(t_xc5_reg) - SW'(t_ys5_reg);
    assign y_sum = $signed(SW'({1'b0, centre_y_reg})) + SW'(t_xs5_reg) + SW'(t_yc5_reg);

    always_ff @(posedge aclk) begin
        if (rdy6 && v5_reg) begin
            x6_reg     <= sat_out(x_sum);
            y6_reg     <= sat_out(y_sum);
            angle6_reg <= angle5_reg;
        end
    end

    assign m_valid         = v6_reg;
    assign m_rotated_x     = x6_reg;
    assign m_rotated_y     = y6_reg;
    assign m_current_angle = angle6_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // angle stays inside one turn
    a_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (AW + 1)'(acc_reg) < WRAP_A)
        else $error("angle accumulator outside one turn");

    // a non-advancing request leaves the angle alone
    a_hold_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_advance |=> $stable(acc_reg))
        else $error("angle moved on a non-advancing request");

    // reciprocal estimate is never more than one short
    a_recip_err: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (rem_comb < (DIV_N << 1)))
        else $error("table index estimate off by more than one");

endmodule
